// File: hw/rtl/u8tc_pkg.sv
// ----------------------------------------------------------------------------
// u8tc_pkg
// Shared types, constants and helpers of the utf8 safe truncating copy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8tc_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int CAP_W        = 13;
    localparam int POS_W        = 13;
    localparam int IDX_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int RUN_MAX      = 4;
    localparam int HOLD_DEPTH   = 3;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(256);
    localparam logic [CAP_W-1:0]  CAP_MAX    = CAP_W'(MAX_CAPACITY);
    localparam logic [CAP_W-1:0]  CAP_MIN    = CAP_W'(1);

    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hc0;
    localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'he0;
    localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hc0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hf0;
    localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'he0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hf8;
    localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hf0;
    localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

    // apb register addresses
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    // one command from front to back: a run of bytes or the terminator
    typedef struct packed {
        logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]               base;
        logic [1:0]                     last_k;
        logic                           term;
    } t_cmd;

    // sequence length from the lead byte, zero when the byte cannot lead
    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            len = 3'd2;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            len = 3'd3;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/u8tc_front.sv
// ----------------------------------------------------------------------------
// u8tc_front
// Accepts source bytes, tracks the utf8 sequence state and issues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8tc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [u8tc_pkg::CAP_W-1:0]   i_capacity,
    input  wire logic                         i_accept,
    input  wire logic [u8tc_pkg::BYTE_W-1:0]  i_byte,
    output u8tc_pkg::t_cmd                    o_cmd,
    output logic                              o_push
);

    logic [u8tc_pkg::POS_W-1:0]  r_wp, n_wp;
    logic [2:0]                  r_seq, n_seq;
    logic [1:0]                  r_bh, n_bh;
    logic [u8tc_pkg::BYTE_W-1:0] r_held [u8tc_pkg::HOLD_DEPTH];
    logic                        r_stop, n_stop;
    logic                        hold_we;

    logic [u8tc_pkg::CAP_W-1:0]  cap;
    logic [2:0]                  len;
    logic                        is_nul;
    logic                        is_cont;
    logic                        no_room;
    logic                        in_seq;

    always_comb begin
        cap = i_capacity;
        if (i_capacity == '0) begin
            cap = u8tc_pkg::CAP_MIN;
        end else if (i_capacity > u8tc_pkg::CAP_MAX) begin
            cap = u8tc_pkg::CAP_MAX;
        end
    end

    assign len     = u8tc_pkg::lead_length(i_byte);
    assign is_nul  = (i_byte == u8tc_pkg::NUL_BYTE);
    assign is_cont = ((i_byte & u8tc_pkg::MASK_CONT) == u8tc_pkg::CODE_CONT);
    assign no_room = ({1'b0, r_wp} + {11'b0, len}) >= {1'b0, cap};
    assign in_seq  = (r_seq > 3'd1) && (r_bh != 2'd0);

    always_comb begin
        n_wp    = r_wp;
        n_seq   = r_seq;
        n_bh    = r_bh;
        n_stop  = r_stop;
        hold_we = 1'b0;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.base = r_wp[u8tc_pkg::IDX_W-1:0];
        if (i_accept) begin
            if (r_stop) begin
                if (is_nul) begin
                    n_wp   = '0;
                    n_seq  = '0;
                    n_bh   = '0;
                    n_stop = 1'b0;
                end
            end else if (in_seq && (is_nul || !is_cont)) begin
                // broken sequence
                o_push   = 1'b1;
                o_cmd.term = 1'b1;
                n_seq    = '0;
                n_bh     = '0;
                if (is_nul) begin
                    n_wp   = '0;
                end else begin
                    n_stop = 1'b1;
                end
            end else if (in_seq && ({1'b0, r_bh} + 3'd1 < r_seq)) begin
                hold_we = 1'b1;
                n_bh    = r_bh + 2'd1;
            end else if (in_seq) begin
                // sequence complete
                o_push = 1'b1;
                for (int k = 0; k < u8tc_pkg::RUN_MAX; k++) begin
                    if (k < u8tc_pkg::HOLD_DEPTH && 2'(k) < r_bh) begin
                        o_cmd.bytes[k] = r_held[k];
                    end else begin
                        o_cmd.bytes[k] = i_byte;
                    end
                end
                o_cmd.last_k = r_bh;
                n_wp  = r_wp + {11'b0, r_bh} + 13'd1;
                n_seq = '0;
                n_bh  = '0;
            end else begin
                n_seq = '0;
                n_bh  = '0;
                if (is_nul || len == 3'd0 || no_room) begin
                    o_push     = 1'b1;
                    o_cmd.term = 1'b1;
                    if (is_nul) begin
                        n_wp = '0;
                    end else begin
                        n_stop = 1'b1;
                    end
                end else if (len == 3'd1) begin
                    o_push         = 1'b1;
                    o_cmd.bytes[0] = i_byte;
                    n_wp           = r_wp + 13'd1;
                end else begin
                    hold_we = 1'b1;
                    n_bh    = 2'd1;
                    n_seq   = len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_seq  <= '0;
            r_bh   <= '0;
            r_stop <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_seq  <= n_seq;
            r_bh   <= n_bh;
            r_stop <= n_stop;
        end
    end

    // in_seq false means a new lead byte lands in slot zero
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            if (in_seq) begin
                r_held[r_bh] <= i_byte;
            end else begin
                r_held[0] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/u8tc_queue.sv
// ----------------------------------------------------------------------------
// u8tc_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8tc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u8tc_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output u8tc_pkg::t_cmd      o_head,
    output logic                o_empty,
    output logic                o_full
);

    u8tc_pkg::t_cmd               r_mem [u8tc_pkg::QDEPTH];
    logic [u8tc_pkg::QPTR_W-1:0]  r_wr, r_rd;
    logic [u8tc_pkg::QPTR_W:0]    r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (u8tc_pkg::QPTR_W+1)'(u8tc_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/u8tc_back.sv
// ----------------------------------------------------------------------------
// u8tc_back
// Unpacks queued commands into result beats behind an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8tc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire u8tc_pkg::t_cmd               i_head,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [u8tc_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [u8tc_pkg::IDX_W-1:0]        o_out_index,
    output logic                              o_string_done,
    output logic                              o_run_last
);

    logic       r_valid;
    logic [1:0] r_k;
    logic       load;
    logic       at_last;

    logic [u8tc_pkg::BYTE_W-1:0] r_byte;
    logic [u8tc_pkg::IDX_W-1:0]  r_index;
    logic                        r_done;
    logic                        r_last;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign at_last = (r_k == i_head.last_k);
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= at_last ? 2'd0 : r_k + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= i_head.bytes[r_k];
            r_index <= i_head.base + {10'b0, r_k};
            r_done  <= i_head.term;
            r_last  <= at_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_out_index   = r_index;
    assign o_string_done = r_done;
    assign o_run_last    = r_last;

endmodule

`default_nettype wire

// File: hw/rtl/utf8_safe_truncating_copy.sv
// ----------------------------------------------------------------------------
// utf8_safe_truncating_copy
// Copies a nul-terminated byte string, keeping only whole utf8 sequences.
// ----------------------------------------------------------------------------
// channel   direction  valid    stall    beat
// input     in         i_valid  o_stall  i_in_byte
// output    out        o_valid  i_stall  o_out_byte, o_out_index,
//                                        o_string_done, o_run_last
// config    apb        psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// one input byte per cycle while o_stall is low; results leave at one beat per cycle while i_stall is low
// a run of n bytes leaves as n beats; each passes through a queue entry and then the output register
// a four-entry command queue absorbs runs; o_stall is high while it is full
// reset clears the string state and sets the capacity to 256
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_safe_truncating_copy (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [1:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [u8tc_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [u8tc_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [u8tc_pkg::IDX_W-1:0]        o_out_index,
    output logic                              o_string_done,
    output logic                              o_run_last
);

    logic [u8tc_pkg::CAP_W-1:0] r_cap;
    logic                       accept;
    logic                       push;
    logic                       pop;
    logic                       q_empty;
    logic                       q_full;
    u8tc_pkg::t_cmd             cmd;
    u8tc_pkg::t_cmd             head;

    assign pready = 1'b1;
    assign prdata = (paddr == u8tc_pkg::ADDR_CAPACITY) ? {19'b0, r_cap} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= u8tc_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == u8tc_pkg::ADDR_CAPACITY) begin
            r_cap <= pwdata[u8tc_pkg::CAP_W-1:0];
        end
    end

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    u8tc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_cap),
        .i_accept   (accept),
        .i_byte     (i_in_byte),
        .o_cmd      (cmd),
        .o_push     (push)
    );

    u8tc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    u8tc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_out_index   (o_out_index),
        .o_string_done (o_string_done),
        .o_run_last    (o_run_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    a_done_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_done) |-> (o_out_byte == u8tc_pkg::NUL_BYTE && o_run_last))
        else $error("terminator beat is not a lone zero");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from an empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");

endmodule

`default_nettype wire

// File: tb/sv/utf8_safe_truncating_copy_test.sv
// ----------------------------------------------------------------------------
// utf8_safe_truncating_copy_test
// Sends byte strings through the copy block, predicts every output beat and
// checks each one. A short directed pass covers whole sequences of every
// length, bad lead and continuation bytes, a nul inside a sequence and the
// swallowing of bytes after a stop. Random phases then run under several
// capacities, including both out-of-range values and changes made while a
// string is still open, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_safe_truncating_copy_test;

    import u8tc_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              done;
        logic              last;
    } t_copy_beat;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [1:0]        paddr         = ADDR_CAPACITY;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_in_byte     = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic [IDX_W-1:0]  o_out_index;
    logic              o_string_done;
    logic              o_run_last;

    // predicted copy state
    bit [CAP_W-1:0]    capacity_reg = CAP_RESET;
    bit [POS_W-1:0]    write_pos;
    bit [2:0]          seq_len;
    bit [1:0]          held_cnt;
    bit [BYTE_W-1:0]   held [HOLD_DEPTH];
    bit                stopped;

    bit [BYTE_W-1:0]   pending_bytes [$];
    t_copy_beat        expected_beats [$];

    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                failures      = 0;
    int                bytes_sent    = 0;
    int                beats_checked = 0;
    int                strings_ended = 0;
    int unsigned       quiet_cycles  = 0;

    bit [CAP_W-1:0]    capacity_plan [PHASES] = '{13'd4096, 13'd1, 13'd300, 13'd0,
                                                 13'd17, 13'd8191, 13'd2, 13'd6};
    int                send_idle_plan [4] = '{0, 48, 0, 8};
    int                stall_plan [4]     = '{0, 0, 48, 8};
    bit [BYTE_W-1:0]   directed_bytes [25] = '{
        8'h41, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
        8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h00,
        8'hff, 8'h41, 8'h00,
        8'hc3, 8'h41, 8'h00,
        8'he2, 8'h82, 8'h00
    };

    utf8_safe_truncating_copy dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int usable_capacity();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > MAX_CAPACITY) return MAX_CAPACITY;
        return int'(capacity_reg);
    endfunction

    function automatic void add_result(input bit [7:0] data, input int pos,
                                       input bit done, input bit last);
        t_copy_beat beat;
        beat.data  = data;
        beat.index = IDX_W'(pos);
        beat.done  = done;
        beat.last  = last;
        expected_beats.push_back(beat);
    endfunction

    function automatic void clear_string();
        write_pos = '0;
        seq_len   = '0;
        held_cnt  = '0;
        stopped   = 1'b0;
    endfunction

    function automatic void stop_copy(input bit [7:0] b);
        add_result(NUL_BYTE, int'(write_pos), 1'b1, 1'b1);
        if (b == NUL_BYTE) begin
            clear_string();
        end else begin
            seq_len  = '0;
            held_cnt = '0;
            stopped  = 1'b1;
        end
    endfunction

    function automatic void predict_copy(input bit [7:0] b);
        int cap;
        int len;
        int k;
        cap = usable_capacity();
        if (stopped) begin
            if (b == NUL_BYTE) clear_string();
            return;
        end
        if (seq_len > 1 && held_cnt >= 1) begin
            if (b == NUL_BYTE || b[7:6] != 2'b10) begin
                stop_copy(b);
                return;
            end
            if (int'(held_cnt) + 1 < int'(seq_len)) begin
                held[held_cnt] = b;
                held_cnt++;
                return;
            end
            for (k = 0; k < int'(held_cnt); k++) begin
                add_result(held[k], int'(write_pos) + k, 1'b0, 1'b0);
            end
            add_result(b, int'(write_pos) + int'(held_cnt), 1'b0, 1'b1);
            write_pos = write_pos + POS_W'(held_cnt) + 1'b1;
            seq_len   = '0;
            held_cnt  = '0;
            return;
        end
        seq_len  = '0;
        held_cnt = '0;
        if (b == NUL_BYTE) begin
            stop_copy(b);
            return;
        end
        casez (b)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        if (len == 0 || int'(write_pos) + len >= cap) begin
            stop_copy(b);
        end else if (len == 1) begin
            add_result(b, int'(write_pos), 1'b0, 1'b1);
            write_pos = write_pos + 1'b1;
        end else begin
            held[0]  = b;
            held_cnt = 2'd1;
            seq_len  = 3'(len);
        end
    endfunction

    function automatic void send_byte(input bit [7:0] b);
        pending_bytes.push_back(b);
        bytes_sent++;
    endfunction

    function automatic void send_continuations(input int n);
        repeat (n) send_byte(8'($urandom_range(8'hbf, 8'h80)));
    endfunction

    // one well-formed sequence of 1 to 4 bytes
    function automatic void send_sequence();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            send_byte(8'($urandom_range(8'h7f, 8'h01)));
        end else if (roll < 60) begin
            send_byte(8'($urandom_range(8'hdf, 8'hc0)));
            send_continuations(1);
        end else if (roll < 80) begin
            send_byte(8'($urandom_range(8'hef, 8'he0)));
            send_continuations(2);
        end else begin
            send_byte(8'($urandom_range(8'hf7, 8'hf0)));
            send_continuations(3);
        end
    endfunction

    // a stray byte, or a sequence that a non-continuation byte may cut short
    function automatic void send_noise();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            send_byte(8'($urandom_range(8'hff, 8'h01)));
            return;
        end
        send_byte(8'($urandom_range(8'hf7, 8'hc0)));
        send_continuations($urandom_range(1, 0));
        if (roll < 65) begin
            send_byte(NUL_BYTE);
        end else if (roll < 85) begin
            send_byte(8'($urandom_range(8'h7f, 8'h01)));
        end else begin
            send_byte(8'($urandom_range(8'hff, 8'hc0)));
        end
    endfunction

    function automatic void send_string(input int max_seqs);
        int n;
        n = $urandom_range(max_seqs, 0);
        repeat (n) begin
            if ($urandom_range(99) < 12) send_noise();
            else send_sequence();
        end
        send_byte(NUL_BYTE);
    endfunction

    task automatic write_capacity(input bit [CAP_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (i_valid || pending_bytes.size() != 0);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_in_byte <= '0;
        end else begin
            if (i_valid && !o_stall) predict_copy(i_in_byte);
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_in_byte <= pending_bytes.pop_front();
                end else begin
                    i_valid   <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin : out_monitor
        t_copy_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("beat with nothing expected: out_byte %02h out_index %0d",
                           o_out_byte, o_out_index);
                    failures++;
                end else begin
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (want.done) strings_ended++;
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        failures++;
                    end
                    if (o_out_index !== want.index) begin
                        $error("out_index: expected %0d, got %0d", want.index, o_out_index);
                        failures++;
                    end
                    if (o_string_done !== want.done) begin
                        $error("string_done: expected %0b, got %0b", want.done,
                               o_string_done);
                        failures++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                        failures++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_beats.size());
            $display("** utf8_safe_truncating_copy: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int target;
        int cap;
        clear_string();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        drain();

        for (p = 0; p < PHASES; p++) begin
            write_capacity(capacity_plan[p]);
            send_idle_pct = send_idle_plan[p % 4];
            stall_pct     = stall_plan[p % 4];
            cap    = usable_capacity();
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if (cap < 16) send_string(cap);
                else send_string($urandom_range(7) == 0 ? 24 : 12);
            end
            // leave the string open across the next capacity write
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(8'h7e, 8'h20)));
            send_byte(8'($urandom_range(8'hef, 8'he0)));
            send_continuations(1);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d bytes under %0d capacity settings and four idle patterns",
                 bytes_sent, PHASES + 1);
        $display("checked %0d result beats, %0d of them string terminators",
                 beats_checked, strings_ended);
        if (failures == 0) begin
            $display("** utf8_safe_truncating_copy: PASSED **");
        end else begin
            $display("** utf8_safe_truncating_copy: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/u8tc_pkg.sv
hw/rtl/u8tc_front.sv
hw/rtl/u8tc_queue.sv
hw/rtl/u8tc_back.sv
hw/rtl/utf8_safe_truncating_copy.sv
tb/sv/utf8_safe_truncating_copy_test.sv
